@@ sv/hkq_pkg.sv @@
// Shared types, constants and the usage lookup table for the keyboard key queue.
package hkq_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int KEY_W     = 12;

    localparam logic [1:0] MODE_REPORT = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [7:0] SHIFT_MASK    = 8'h22;
    localparam logic [7:0] USAGE_NONE    = 8'h00;
    localparam logic [7:0] USAGE_ROLLOVR = 8'h01;

    typedef struct packed {
        logic [4:0] scan;
        logic [6:0] plain;
        logic [6:0] shifted;
    } usage_entry_t;

    // Classified report or command, front to back.
    typedef struct packed {
        logic [1:0]                      mode;
        logic [NUM_SLOTS-1:0]            mask;
        logic [NUM_SLOTS-1:0][KEY_W-1:0] keys;
    } cmd_t;

    // US boot-keyboard usage table; all-zero entry means unmapped.
    function automatic usage_entry_t usage_lookup(input logic [7:0] usage);
        usage_entry_t e;
        logic [7:0]   t;
        e = '0;
        t = '0;
        if (usage >= 8'h04 && usage <= 8'h1D) begin
            t = usage + 8'h5D;
            e.plain = t[6:0];
            t = usage + 8'h3D;
            e.shifted = t[6:0];
        end else if (usage >= 8'h3A && usage <= 8'h45) begin
            // function keys F1..F12
            t = usage - 8'h2F;
            e.scan = t[4:0];
        end else begin
            case (usage)
                8'h1E: e = {5'h00, 7'h31, 7'h21};
                8'h1F: e = {5'h00, 7'h32, 7'h40};
                8'h20: e = {5'h00, 7'h33, 7'h23};
                8'h21: e = {5'h00, 7'h34, 7'h24};
                8'h22: e = {5'h00, 7'h35, 7'h25};
                8'h23: e = {5'h00, 7'h36, 7'h5E};
                8'h24: e = {5'h00, 7'h37, 7'h26};
                8'h25: e = {5'h00, 7'h38, 7'h2A};
                8'h26: e = {5'h00, 7'h39, 7'h28};
                8'h27: e = {5'h00, 7'h30, 7'h29};
                8'h28: e = {5'h00, 7'h0D, 7'h0D};
                8'h29: e = {5'h17, 7'h00, 7'h00};
                8'h2A: e = {5'h00, 7'h08, 7'h08};
                8'h2B: e = {5'h00, 7'h09, 7'h09};
                8'h2C: e = {5'h00, 7'h20, 7'h20};
                8'h2D: e = {5'h00, 7'h2D, 7'h5F};
                8'h2E: e = {5'h00, 7'h3D, 7'h2B};
                8'h2F: e = {5'h00, 7'h5B, 7'h7B};
                8'h30: e = {5'h00, 7'h5D, 7'h7D};
                8'h31: e = {5'h00, 7'h5C, 7'h7C};
                8'h33: e = {5'h00, 7'h3B, 7'h3A};
                8'h34: e = {5'h00, 7'h27, 7'h22};
                8'h35: e = {5'h00, 7'h60, 7'h7E};
                8'h36: e = {5'h00, 7'h2C, 7'h3C};
                8'h37: e = {5'h00, 7'h2E, 7'h3E};
                8'h38: e = {5'h00, 7'h2F, 7'h3F};
                8'h49: e = {5'h07, 7'h00, 7'h00};
                8'h4A: e = {5'h05, 7'h00, 7'h00};
                8'h4B: e = {5'h09, 7'h00, 7'h00};
                8'h4C: e = {5'h08, 7'h00, 7'h00};
                8'h4D: e = {5'h06, 7'h00, 7'h00};
                8'h4E: e = {5'h0A, 7'h00, 7'h00};
                8'h4F: e = {5'h03, 7'h00, 7'h00};
                8'h50: e = {5'h04, 7'h00, 7'h00};
                8'h51: e = {5'h02, 7'h00, 7'h00};
                8'h52: e = {5'h01, 7'h00, 7'h00};
                default: e = '0;
            endcase
        end
        return e;
    endfunction

endpackage

@@ sv/hkq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module hkq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hkq_front.sv @@
// Input side: accepts items, diffs reports against the previous one, looks up keys.
module hkq_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          fifo_full,
    output logic          push,
    output hkq_pkg::cmd_t push_cmd
);
    import hkq_pkg::*;

    logic [NUM_SLOTS-1:0][7:0] prev_reg;
    logic [NUM_SLOTS-1:0][7:0] prev_next;
    logic [NUM_SLOTS-1:0][7:0] slots;
    logic [7:0]                modifiers;
    logic                      shift;
    logic [NUM_SLOTS-1:0]      seen;
    usage_entry_t              entry [NUM_SLOTS];

    assign modifiers = s_tdata[7:0];
    assign shift     = (modifiers & SHIFT_MASK) != 8'h00;
    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slots[i] = s_tdata[8 + 8*i +: 8];
        end
    end

    always_comb begin
        push_cmd.mode = s_tuser;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            seen[i] = 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                seen[i] = seen[i] | (prev_reg[j] == slots[i]);
            end
            entry[i] = usage_lookup(slots[i]);
            push_cmd.keys[i] = {entry[i].scan, shift ? entry[i].shifted : entry[i].plain};
            push_cmd.mask[i] = (slots[i] != USAGE_NONE) && (slots[i] != USAGE_ROLLOVR)
                               && !seen[i]
                               && (entry[i].scan != 5'd0 || entry[i].plain != 7'd0);
        end
    end

    always_comb begin
        prev_next = prev_reg;
        if (push && s_tuser == MODE_REPORT) begin
            prev_next = slots;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else begin
            prev_reg <= prev_next;
        end
    end

endmodule

@@ sv/hkq_cmd_fifo.sv @@
// Two-entry command queue between the front and back parts.
module hkq_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hkq_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output hkq_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import hkq_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign pop_cmd = entry_reg[rd_reg];

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = !wr_reg;
        end
        if (pop) begin
            rd_next = !rd_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/hkq_back.sv @@
// Execution side: key ring queue, enqueue sequencer, pop and clear, result register.
module hkq_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  hkq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata
);
    import hkq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ENQ  = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic                            m_valid_reg, m_valid_next;
    logic [23:0]                     m_data_reg, m_data_next;

    logic [2:0]                      slot_reg, slot_next;
    logic [NUM_SLOTS-1:0]            mask_reg, mask_next;
    logic [NUM_SLOTS-1:0][KEY_W-1:0] keys_reg, keys_next;
    logic [2:0]                      added_reg, added_next;
    logic                            key_valid_reg, key_valid_next;
    logic [KEY_W-1:0]                key_reg, key_next;
    logic                            status_reg, status_next;

    logic                            ram_we, ram_re;
    logic [KEY_W-1:0]                ram_rdata;
    logic                            has_room;

    assign has_room = fill_reg < CNT_W'(QUEUE_DEPTH);

    hkq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_key_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (keys_reg[slot_reg]),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        slot_next      = slot_reg;
        mask_next      = mask_reg;
        keys_next      = keys_reg;
        added_next     = added_reg;
        key_valid_next = key_valid_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        cmd_pop        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop        = 1'b1;
                    mask_next      = cmd.mask;
                    keys_next      = cmd.keys;
                    slot_next      = 3'd0;
                    added_next     = 3'd0;
                    key_valid_next = 1'b0;
                    key_next       = '0;
                    status_next    = 1'b0;
                    state_next     = ST_DONE;
                    unique case (cmd.mode)
                        MODE_REPORT: begin
                            state_next = ST_ENQ;
                        end
                        MODE_POP: begin
                            if (fill_reg == '0) begin
                                status_next = 1'b1;
                            end else begin
                                ram_re      = 1'b1;
                                rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                              '0 : rd_ptr_reg + PTR_W'(1);
                                fill_next   = fill_reg - CNT_W'(1);
                                state_next  = ST_READ;
                            end
                        end
                        MODE_CLEAR: begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            fill_next   = '0;
                        end
                        default: begin
                            // unused mode: no change, result reports current fill
                        end
                    endcase
                end
            end
            ST_ENQ: begin
                if (mask_reg[slot_reg] && has_room) begin
                    ram_we      = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : wr_ptr_reg + PTR_W'(1);
                    fill_next   = fill_reg + CNT_W'(1);
                    added_next  = added_reg + 3'd1;
                end
                if (slot_reg == 3'(NUM_SLOTS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    slot_next = slot_reg + 3'd1;
                end
            end
            ST_READ: begin
                key_valid_next = 1'b1;
                key_next       = ram_rdata;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, 6'(fill_reg), added_reg, status_reg,
                                    key_reg[6:0], key_reg[11:7], key_valid_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        slot_reg      <= slot_next;
        mask_reg      <= mask_next;
        keys_reg      <= keys_next;
        added_reg     <= added_next;
        key_valid_reg <= key_valid_next;
        key_reg       <= key_next;
        status_reg    <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    logic [CNT_W:0] ptr_sum;
    logic [CNT_W:0] ptr_wrap;
    assign ptr_sum  = {1'b0, fill_reg} + (CNT_W+1)'(rd_ptr_reg);
    assign ptr_wrap = (ptr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                      ptr_sum - (CNT_W+1)'(QUEUE_DEPTH) : ptr_sum;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("key queue fill beyond depth");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg == PTR_W'(ptr_wrap))
        else $error("write pointer out of step with read pointer and fill");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> state_reg != ST_IDLE)
        else $error("command taken but sequencer stayed idle");

    a_result_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[13]) && m_data_reg[16:14] <= 3'd6)
        else $error("inconsistent result item");
`endif

endmodule

@@ sv/hid_keyboard_report_to_key_queue.sv @@
// Top level: boot-keyboard report decoder feeding a key event ring queue.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser: mode; tdata: modifiers, usage slots 0..5
//  m_      | out | m_tvalid/m_tready  | tdata: key_valid, scan_code, char_code, status,
//          |     |                    |        keys_added, queue_fill
//
// A report: front diff and lookup, then the back sequencer steps through all six slots,
// one a cycle, writing each new mapped key into the single-write-port key store if room.
// A pop passes through a registered read of the key store; a clear goes straight to its result.
// A two-entry command queue lets the front take items while the back is busy.
// Reset (aresetn low, synchronous) empties the queue and zeroes the previous usages.
// A stalled m_ side holds the result; the back waits, the front fills its queue.
module hid_keyboard_report_to_key_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // modifiers[7:0], usage_slot_0..usage_slot_5 8 bits each
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // key_valid, scan_code[4:0], char_code[6:0], status,
                                  // keys_added[2:0], queue_fill[5:0], zero pad
);
    import hkq_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic fifo_full;
    logic fifo_empty;
    logic cmd_pop;
    cmd_t pop_cmd;

    hkq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    hkq_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (cmd_pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    hkq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!fifo_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
